// File: hdl/ssa_pkg.sv
package ssa_pkg;

  localparam int ModeW     = 2;
  localparam int StatusW   = 2;
  localparam int PidW      = 16;
  localparam int PageW     = 16;
  localparam int CountW    = 9;
  localparam int SlotOutW  = 8;
  localparam int OffsetW   = 24;
  localparam int PsizeW    = 17;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 64;
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 17;

  localparam logic [CountW-1:0] SlotsReset = 9'd256;
  localparam logic [PsizeW-1:0] PsizeReset = 17'd256;

  localparam logic [CfgIndexW-1:0] CFG_SLOTS_IN_USE = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_PAGE_SIZE    = 1'b1;

  typedef enum logic [ModeW-1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_END   = 2'd2,
    MODE_NEW   = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_NO_FREE   = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_MOVE  = 6'b001000,
    ST_WIPE  = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

// File: hdl/swap_slot_allocator_with_compaction_top.sv
// Swap slot allocator: a table of MAX_SLOTS slots, each with a used bit and an
// (owner pid, page) tag, held in one RAM with one write and one registered read
// port. Every request walks the first n slots (n = slots_in_use, capped at
// MAX_SLOTS) one slot per clock. Write, read and end-program need that walk
// alone; new-process needs the same when the largest free hole is big enough,
// and when it compacts a second walk moves used slots down, then a tail pass
// clears the slots left behind. After reset the block clears all MAX_SLOTS
// slots of the table and takes no request meanwhile; configuration writes
// are taken at any time but are meant for an idle block.
// One request is worked at a time; its result sits in an output register, so
// the next request is taken while the previous result waits.
module swap_slot_allocator_with_compaction_top #(
  parameter int MAX_SLOTS = 256,
  parameter int PID_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ssa_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [ssa_pkg::CfgDataW-1:0]      cfg_data_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pid [15:0], page_number [31:16], pages_needed [40:32], zero pad
  input  logic [ssa_pkg::InDataW-1:0]       s_axis_tdata,
  // mode [1:0]
  input  logic [ssa_pkg::ModeW-1:0]         s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // slot_index [7:0], byte_offset [31:8], free_slots [40:32],
  // pages_released [49:41], largest_hole [58:50], compacted [59], zero pad
  output logic [ssa_pkg::OutDataW-1:0]      m_axis_tdata,
  // status [1:0]
  output logic [ssa_pkg::StatusW-1:0]       m_axis_tuser
);
  import ssa_pkg::*;

  localparam int IdxW = $clog2(MAX_SLOTS);
  localparam int CntW = $clog2(MAX_SLOTS + 1);
  localparam int OwnW = PID_BITS;
  localparam int EntW = OwnW + PageW + 1;
  localparam int ProdW = IdxW + PsizeW;
  localparam logic [CntW-1:0] LastSlot = CntW'(MAX_SLOTS - 1);

  // configuration
  logic [CountW-1:0] slots_q;
  logic [PsizeW-1:0] psize_q;

  // sequencer and request
  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [OwnW-1:0]  owner_q, owner_d;
  logic [PageW-1:0] page_q, page_d;
  logic [CountW-1:0] need_q, need_d;
  logic [CntW-1:0]  n_q, n_d;

  // walk
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rvld_q, rvld_d;
  logic [IdxW-1:0]  ridx_q, ridx_d;
  logic [CntW-1:0]  dst_q, dst_d;

  // accumulators
  logic [CntW-1:0]  free_q, free_d;
  logic [CntW-1:0]  rel_q, rel_d;
  logic [CntW-1:0]  run_q, run_d;
  logic [CntW-1:0]  best_q, best_d;
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic             hole_q, hole_d;
  logic [IdxW-1:0]  hole_idx_q, hole_idx_d;

  // result
  status_e          res_status_q, res_status_d;
  logic [IdxW-1:0]  res_slot_q, res_slot_d;
  logic             res_did_q, res_did_d;

  logic                 m_valid_q, m_valid_d;
  logic [OutDataW-1:0]  m_data_q, m_data_d;
  logic [StatusW-1:0]   m_user_q, m_user_d;

  // RAM
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [EntW-1:0]  ram_wdata;
  logic [IdxW-1:0]  ram_raddr;
  logic [EntW-1:0]  ram_rdata;

  logic             e_used;
  logic [OwnW-1:0]  e_owner;
  logic [PageW-1:0] e_page;
  logic             own_hit;
  logic             tag_hit;
  logic             walk_done;
  logic             issue;
  logic [CntW-1:0]  n_calc;
  logic [ProdW-1:0] prod;

  ssa_ram #(
    .WIDTH (EntW),
    .DEPTH (MAX_SLOTS)
  ) u_tags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign e_owner = ram_rdata[OwnW-1:0];
  assign e_page  = ram_rdata[OwnW+PageW-1:OwnW];
  assign e_used  = ram_rdata[EntW-1];
  assign own_hit = e_used && (e_owner == owner_q);
  assign tag_hit = own_hit && (e_page == page_q);

  assign issue     = cnt_q < n_q;
  assign walk_done = !rvld_q && (cnt_q == n_q);
  assign ram_raddr = cnt_q[IdxW-1:0];

  assign n_calc = (32'(slots_q) > 32'(MAX_SLOTS)) ? CntW'(MAX_SLOTS) : CntW'(slots_q);
  assign prod   = ProdW'(res_slot_q) * ProdW'(psize_q);

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= SlotsReset;
      psize_q <= PsizeReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SLOTS_IN_USE: slots_q <= cfg_data_i[CountW-1:0];
        CFG_PAGE_SIZE:    psize_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    owner_d      = owner_q;
    page_d       = page_q;
    need_d       = need_q;
    n_d          = n_q;
    cnt_d        = cnt_q;
    rvld_d       = 1'b0;
    ridx_d       = ridx_q;
    dst_d        = dst_q;
    free_d       = free_q;
    rel_d        = rel_q;
    run_d        = run_q;
    best_d       = best_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hole_d       = hole_q;
    hole_idx_d   = hole_idx_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_did_d    = res_did_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    ram_we       = 1'b0;
    ram_waddr    = ridx_q;
    ram_wdata    = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[IdxW-1:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d       = mode_e'(s_axis_tuser);
          owner_d      = OwnW'(s_axis_tdata[15:0]);
          page_d       = s_axis_tdata[31:16];
          need_d       = s_axis_tdata[40:32];
          n_d          = n_calc;
          cnt_d        = '0;
          free_d       = '0;
          rel_d        = '0;
          run_d        = '0;
          best_d       = '0;
          hit_d        = 1'b0;
          hole_d       = 1'b0;
          res_status_d = STAT_OK;
          res_slot_d   = '0;
          res_did_d    = 1'b0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (issue) begin
          rvld_d = 1'b1;
          ridx_d = cnt_q[IdxW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (rvld_q) begin
          case (mode_q)
            MODE_WRITE, MODE_READ: begin
              if (tag_hit && !hit_q) begin
                hit_d     = 1'b1;
                hit_idx_d = ridx_q;
              end
              if (!e_used) begin
                free_d = free_q + 1'b1;
                if (!hole_q) begin
                  hole_d     = 1'b1;
                  hole_idx_d = ridx_q;
                end
              end
            end
            MODE_END: begin
              if (own_hit) begin
                // drop the used bit in place
                ram_we    = 1'b1;
                ram_waddr = ridx_q;
                ram_wdata = {1'b0, ram_rdata[EntW-2:0]};
                rel_d     = rel_q + 1'b1;
              end
              if (own_hit || !e_used) begin
                free_d = free_q + 1'b1;
              end
            end
            MODE_NEW: begin
              if (!e_used) begin
                free_d = free_q + 1'b1;
                run_d  = run_q + 1'b1;
                if (run_q + 1'b1 > best_q) begin
                  best_d = run_q + 1'b1;
                end
              end else begin
                run_d = '0;
              end
            end
            default: ;
          endcase
        end
        if (walk_done) begin
          state_d = ST_FIN;
          if (mode_q inside {MODE_WRITE, MODE_READ}) begin
            if (hit_q) begin
              res_slot_d = hit_idx_q;
            end else if (mode_q == MODE_READ) begin
              res_status_d = STAT_NOT_FOUND;
            end else if (hole_q) begin
              ram_we     = 1'b1;
              ram_waddr  = hole_idx_q;
              ram_wdata  = {1'b1, page_q, owner_q};
              res_slot_d = hole_idx_q;
              free_d     = free_q - 1'b1;
            end else begin
              res_status_d = STAT_NO_FREE;
            end
          end else if (mode_q == MODE_NEW && (32'(best_q) < 32'(need_q))) begin
            res_did_d = 1'b1;
            cnt_d     = '0;
            dst_d     = '0;
            state_d   = ST_MOVE;
          end
        end
      end

      ST_MOVE: begin
        // reads run ahead of the write pointer, so no moved slot is read back
        if (issue) begin
          rvld_d = 1'b1;
          ridx_d = cnt_q[IdxW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (rvld_q && e_used) begin
          dst_d = dst_q + 1'b1;
          if (32'(ridx_q) != 32'(dst_q)) begin
            ram_we    = 1'b1;
            ram_waddr = dst_q[IdxW-1:0];
            ram_wdata = ram_rdata;
          end
        end
        if (walk_done) begin
          state_d = ST_WIPE;
        end
      end

      ST_WIPE: begin
        // everything from the packed end up to n is free after the move
        if (dst_q < n_q) begin
          ram_we    = 1'b1;
          ram_waddr = dst_q[IdxW-1:0];
          dst_d     = dst_q + 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = res_status_q;
          m_data_d  = {4'b0000, res_did_q, CountW'(best_q), CountW'(rel_q),
                       CountW'(free_q), OffsetW'(prod), SlotOutW'(res_slot_q)};
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cnt_q     <= '0;
      rvld_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rvld_q    <= rvld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    owner_q      <= owner_d;
    page_q       <= page_d;
    need_q       <= need_d;
    n_q          <= n_d;
    ridx_q       <= ridx_d;
    dst_q        <= dst_d;
    free_q       <= free_d;
    rel_q        <= rel_d;
    run_q        <= run_d;
    best_q       <= best_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    hole_q       <= hole_d;
    hole_idx_q   <= hole_idx_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_did_q    <= res_did_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

endmodule

// File: hdl/ssa_ram.sv
module ssa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
